[hdl/ils_pkg.sv]
`timescale 1ns / 1ps

package ils_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 10;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_APPEND = 3'd0;
    localparam t_opcode OP_INSERT = 3'd1;
    localparam t_opcode OP_REMOVE = 3'd2;
    localparam t_opcode OP_GET    = 3'd3;
    localparam t_opcode OP_SET    = 3'd4;
    localparam t_opcode OP_CLEAR  = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

[hdl/ils_ram.sv]
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/indexed_list_store.sv]
`timescale 1ns / 1ps
// Accepted ops pass to S_RESP: append, set, clear and failed ops directly; get through S_DRAIN;
// remove through S_MOVE and S_DRAIN; insert inside the list through S_MOVE, S_DRAIN and S_FILL;
// insert past the end through S_FILL. One item in flight at a time.
// Throughput is set by the single memory write port: one entry moved per cycle.
// Reset (synchronous, active low) empties the list; entry contents stay undefined.

module indexed_list_store #(
    parameter int DEPTH      = 1024,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ils_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [ils_pkg::POS_W-1:0]     i_position,
    input  logic [ils_pkg::WORD_W-1:0]    i_word_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ils_pkg::WORD_W-1:0]    o_word_out,
    output logic [ils_pkg::COUNT_W-1:0]   o_count,
    output logic [ils_pkg::STATUS_W-1:0]  o_status
);

    import ils_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int EXT_W  = (WORD_WIDTH > WORD_W) ? WORD_WIDTH : WORD_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOVE  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_end, n_end;
    logic [AW-1:0]         r_waddr, n_waddr;
    logic                  r_up, n_up;
    logic                  r_first, n_first;
    logic                  r_wpend, n_wpend;
    logic                  r_cap, n_cap;
    logic [WORD_W-1:0]     r_word, n_word;
    t_status               r_status, n_status;
    logic [WORD_WIDTH-1:0] r_wdata, n_wdata;

    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_word;
    logic [COUNT_W-1:0]    r_out_count;
    t_status               r_out_status;
    logic                  load;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [WORD_WIDTH-1:0] mem_wdata, rd_data;

    logic                  in_fire;
    logic [CMP_W-1:0]      pos_x, cnt_x, pos_inc;
    logic [AW-1:0]         pos_a, cnt_a, cnt_m1;
    logic [CNT_W-1:0]      cnt_dec;
    logic [EXT_W-1:0]      win_ext, rd_ext;
    logic [WORD_WIDTH-1:0] w_in;

    ils_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign pos_x   = CMP_W'(i_position);
    assign cnt_x   = CMP_W'(r_count);
    assign pos_inc = pos_x + CMP_W'(1);
    assign pos_a   = pos_x[AW-1:0];
    assign cnt_a   = r_count[AW-1:0];
    assign cnt_dec = r_count - CNT_W'(1);
    assign cnt_m1  = cnt_dec[AW-1:0];
    assign win_ext = EXT_W'(i_word_in);
    assign w_in    = win_ext[WORD_WIDTH-1:0];
    assign rd_ext  = EXT_W'(rd_data);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_addr    = r_addr;
        n_end     = r_end;
        n_waddr   = r_waddr;
        n_up      = r_up;
        n_first   = r_first;
        n_wpend   = 1'b0;
        n_cap     = 1'b0;
        n_word    = r_word;
        n_status  = r_status;
        n_wdata   = r_wdata;
        load      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = rd_data;
        mem_re    = 1'b0;
        mem_raddr = r_addr;

        // pending shift write from the previous read
        if (r_wpend) begin
            mem_we = 1'b1;
        end
        if (r_cap) begin
            n_word = rd_ext[WORD_W-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_word   = '0;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    n_wdata  = w_in;
                    unique case (i_opcode)
                        OP_APPEND: begin
                            if (cnt_x == DEPTH_X) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_a;
                                mem_wdata = w_in;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_INSERT: begin
                            if (pos_x < cnt_x) begin
                                if (cnt_x == DEPTH_X) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_count = r_count + CNT_W'(1);
                                    n_addr  = cnt_m1;
                                    n_end   = pos_a;
                                    n_up    = 1'b1;
                                    n_first = 1'b1;
                                    n_state = S_MOVE;
                                end
                            end else if (pos_x >= DEPTH_X) begin
                                n_status = ST_FULL;
                            end else begin
                                n_addr  = cnt_a;
                                n_end   = pos_a;
                                n_count = pos_inc[CNT_W-1:0];
                                n_state = S_FILL;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_addr  = pos_a;
                                n_end   = cnt_m1;
                                n_up    = 1'b0;
                                n_first = 1'b1;
                                n_count = cnt_dec;
                                n_state = S_MOVE;
                            end
                        end
                        OP_GET: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = pos_a;
                                n_cap     = 1'b1;
                                n_up      = 1'b0;
                                n_state   = S_DRAIN;
                            end
                        end
                        OP_SET: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_a;
                                mem_wdata = w_in;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOVE: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr;
                n_first   = 1'b0;
                // on remove the first read is the taken entry, not a shift
                n_wpend   = r_up | ~r_first;
                n_cap     = ~r_up & r_first;
                n_waddr   = r_up ? (r_addr + AW'(1)) : (r_addr - AW'(1));
                if (r_addr == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_up ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                end
            end
            S_DRAIN: begin
                n_state = r_up ? S_FILL : S_RESP;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                if (r_addr == r_end) begin
                    mem_wdata = r_wdata;
                    n_state   = S_RESP;
                end else begin
                    mem_wdata = '0;
                    n_addr    = r_addr + AW'(1);
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_cap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
            r_cap   <= n_cap;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_end    <= n_end;
        r_waddr  <= n_waddr;
        r_up     <= n_up;
        r_first  <= n_first;
        r_word   <= n_word;
        r_status <= n_status;
        r_wdata  <= n_wdata;
        if (load) begin
            r_out_word   <= r_word;
            r_out_count  <= cnt_x[COUNT_W-1:0];
            r_out_status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word_out  = r_out_word;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= DEPTH_X)
        else $error("entry count above depth");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transfer accepted while busy");

    a_fail_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_word_out == '0))
        else $error("failed operation returned a word");
`endif

endmodule
